// ===== hdl/dhpd_pkg.sv =====
// Shared types, codes and constants of the debounced hold/press detector.
// No dependencies; imported by every module of the block.
package dhpd_pkg;

  // Width of the internal time base; stamps are cast to this width.
  localparam int TIME_BITS = 32;

  localparam int STAMP_W    = 32;
  localparam int REG_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int IN_DATA_W  = 56;  // 51 bits of fields, padded to bytes
  localparam int OUT_DATA_W = 8;   // 7 bits of fields, padded to a byte

  typedef logic [TIME_BITS-1:0] time_t;

  typedef enum logic [1:0] {
    OP_SAMPLE       = 2'd0,
    OP_RESET_CD     = 2'd1,
    OP_SET_DIRECT   = 2'd2,
    OP_CLEAR_DIRECT = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE    = 3'd0,
    CFG_HOLD        = 3'd1,
    CFG_SHORT_MIN   = 3'd2,
    CFG_STOP_CD     = 3'd3,
    CFG_TOGGLE_CD   = 3'd4
  } cfg_idx_t;

  localparam logic [REG_W-1:0] DEBOUNCE_RST  = 16'd30;
  localparam logic [REG_W-1:0] HOLD_RST      = 16'd300;
  localparam logic [REG_W-1:0] SHORT_MIN_RST = 16'd50;
  localparam logic [REG_W-1:0] STOP_CD_RST   = 16'd700;
  localparam logic [REG_W-1:0] TOGGLE_CD_RST = 16'd350;

  typedef struct packed {
    logic [REG_W-1:0] settle_ms;
    logic [REG_W-1:0] hold_ms;
    logic [REG_W-1:0] short_min_ms;
    logic [REG_W-1:0] stop_cooldown_ms;
    logic [REG_W-1:0] toggle_cooldown_ms;
  } cfg_t;

  typedef struct packed {
    op_t              opcode;
    logic [STAMP_W-1:0] now_ms;
    logic             raw_level;
    logic             is_recording;
    logic             is_sleeping;
    logic [REG_W-1:0] cooldown_ms;
  } item_t;

  typedef struct packed {
    logic  last_raw;
    time_t last_change_time;
    logic  pressed;
    time_t press_start_time;
    logic  hold_fired;
    time_t cooldown_until;
    logic  direct_flag;
  } state_t;

  typedef struct packed {
    logic record_start;
    logic stop_request;
    logic sleep_toggle;
    logic wake_request;
    logic activity_report;
    logic pressed_level;
    logic direct_record;
  } result_t;

endpackage

// ===== hdl/dhpd_step.sv =====
// Combinational next-state and result logic for one item.
// Depends on dhpd_pkg.
module dhpd_step import dhpd_pkg::*; (
  input  item_t   item,
  input  state_t  st,
  input  cfg_t    cfg,
  output state_t  st_next,
  output result_t res
);

  time_t t;
  time_t since_change;
  time_t held;
  logic  raw_changed;
  logic  settled;
  logic  down;
  logic  locked;

  assign t            = time_t'(item.now_ms);
  assign raw_changed  = (item.raw_level != st.last_raw);
  // a change restarts the settle timer at zero
  assign since_change = raw_changed ? '0 : (t - st.last_change_time);
  assign settled      = (since_change >= time_t'(cfg.settle_ms));
  assign down         = ~item.raw_level;
  assign locked       = (t < st.cooldown_until);
  assign held         = t - st.press_start_time;

  always_comb begin
    st_next = st;
    res     = '0;
    case (item.opcode)
      OP_RESET_CD: begin
        st_next.hold_fired     = 1'b0;
        st_next.direct_flag    = 1'b0;
        st_next.cooldown_until = t + time_t'(item.cooldown_ms);
      end
      OP_SET_DIRECT: begin
        st_next.direct_flag = 1'b1;
      end
      OP_CLEAR_DIRECT: begin
        st_next.direct_flag = 1'b0;
      end
      OP_SAMPLE: begin
        if (raw_changed) begin
          st_next.last_change_time = t;
          st_next.last_raw         = item.raw_level;
        end
        if (settled) begin
          if (locked) begin
            st_next.pressed = down;
          end else if (down && !st.pressed) begin
            st_next.pressed          = 1'b1;
            st_next.press_start_time = t;
            st_next.hold_fired       = 1'b0;
          end else if (down) begin
            if (!st.hold_fired && held >= time_t'(cfg.hold_ms)) begin
              st_next.hold_fired  = 1'b1;
              st_next.direct_flag = 1'b1;
              res.record_start    = 1'b1;
              res.wake_request    = item.is_sleeping;
              res.activity_report = ~item.is_sleeping;
            end
          end else if (st.pressed) begin
            st_next.pressed    = 1'b0;
            st_next.hold_fired = 1'b0;
            if (st.hold_fired || item.is_recording) begin
              res.stop_request       = 1'b1;
              st_next.direct_flag    = 1'b0;
              st_next.cooldown_until = t + time_t'(cfg.stop_cooldown_ms);
            end else if (held >= time_t'(cfg.short_min_ms) &&
                         held < time_t'(cfg.hold_ms)) begin
              res.sleep_toggle       = 1'b1;
              st_next.cooldown_until = t + time_t'(cfg.toggle_cooldown_ms);
            end
          end
        end
      end
      default: begin
        st_next = st;
      end
    endcase
    res.pressed_level = st_next.pressed;
    res.direct_record = st_next.direct_flag;
  end

endmodule

// ===== hdl/debounced_hold_press_detector_core.sv =====
// Top level of the debounced hold/press detector: stream ports, config
// registers, state and pipeline registers. Depends on dhpd_pkg, dhpd_step.
//
// One item is one poll of an active-low button or one command, and every
// item gives exactly one result item. The block takes a new item every
// clock cycle while the result register is not stalled; a result shows on
// the master side after its item passes the input register and then the
// result register. The next state is computed in dhpd_step: each item
// reads the state the previous item left and writes the new state in the
// same cycle, so no bypassing is needed. Backpressure on m_tready stalls
// both stages; an item can still enter while a finished result waits, as
// long as the input register is free. Config registers reset to
// 30/300/50/700/350 ms and are meant to be written only while no item is
// in flight. After rst the block is ready at once; there is no clearing
// pass.
module debounced_hold_press_detector_core import dhpd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // input items
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [31:0] now_ms, [32] raw_level, [33] is_recording, [34] is_sleeping,
  // [50:35] cooldown_ms, [55:51] zero
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // [1:0] opcode
  input  logic [1:0]            s_tuser,
  // result items
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [0] record_start, [1] stop_request, [2] sleep_toggle, [3] wake_request,
  // [4] activity_report, [5] pressed_level, [6] direct_record, [7] zero
  output logic [OUT_DATA_W-1:0] m_tdata,
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [REG_W-1:0]      cfg_data
);

  cfg_t    cfg;
  state_t  st;
  state_t  st_next;
  item_t   in_item;
  item_t   stg_item;
  logic    stg_valid;
  result_t res;
  result_t out_res;
  logic    out_valid;
  logic    out_stall;
  logic    fire;
  logic    accept;

  // unpack the stream fields
  assign in_item.opcode       = op_t'(s_tuser);
  assign in_item.now_ms       = s_tdata[31:0];
  assign in_item.raw_level    = s_tdata[32];
  assign in_item.is_recording = s_tdata[33];
  assign in_item.is_sleeping  = s_tdata[34];
  assign in_item.cooldown_ms  = s_tdata[50:35];

  // handshake: result register stalls only when held and not taken
  assign out_stall = out_valid && !m_tready;
  assign fire      = stg_valid && !out_stall;
  assign s_tready  = !stg_valid || !out_stall;
  assign accept    = s_tvalid && s_tready;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.settle_ms          <= DEBOUNCE_RST;
      cfg.hold_ms            <= HOLD_RST;
      cfg.short_min_ms       <= SHORT_MIN_RST;
      cfg.stop_cooldown_ms   <= STOP_CD_RST;
      cfg.toggle_cooldown_ms <= TOGGLE_CD_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_DEBOUNCE:  cfg.settle_ms          <= cfg_data;
        CFG_HOLD:      cfg.hold_ms            <= cfg_data;
        CFG_SHORT_MIN: cfg.short_min_ms       <= cfg_data;
        CFG_STOP_CD:   cfg.stop_cooldown_ms   <= cfg_data;
        CFG_TOGGLE_CD: cfg.toggle_cooldown_ms <= cfg_data;
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (accept) begin
      stg_valid <= 1'b1;
    end else if (fire) begin
      stg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_item <= in_item;
    end
  end

  dhpd_step u_step (
    .item    (stg_item),
    .st      (st),
    .cfg     (cfg),
    .st_next (st_next),
    .res     (res)
  );

  // detector state, updated once per item
  always_ff @(posedge clk) begin
    if (rst) begin
      st.last_raw         <= 1'b1;
      st.last_change_time <= '0;
      st.pressed          <= 1'b0;
      st.press_start_time <= '0;
      st.hold_fired       <= 1'b0;
      st.cooldown_until   <= '0;
      st.direct_flag      <= 1'b0;
    end else if (fire) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_res.direct_record, out_res.pressed_level,
                     out_res.activity_report, out_res.wake_request,
                     out_res.sleep_toggle, out_res.stop_request,
                     out_res.record_start};

endmodule

// ===== hdl/dhpd_checker.sv =====
// Port-level checks for debounced_hold_press_detector_core, bound to it below.
// Depends on dhpd_pkg for the stream widths.
module dhpd_checker import dhpd_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  // no result item comes out of reset
  a_idle_after_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // start, stop and toggle never fire together
  a_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $countones(m_tdata[2:0]) <= 1)
    else $error("more than one event pulse");

  // exactly one of wake or activity goes with a record start
  a_wake_act: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[3] ^ m_tdata[4]) == m_tdata[0]))
    else $error("wake/activity not paired with record start");

  // a start leaves the button pressed and direct record set; a stop clears both
  a_levels: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[0] || m_tdata[1]) |->
      (m_tdata[5] == m_tdata[0]) && (m_tdata[6] == m_tdata[0]))
    else $error("level flags disagree with start/stop pulse");

endmodule

bind debounced_hold_press_detector_core dhpd_checker u_dhpd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
